// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules of the fold shaper.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tsfs_pkg.sv =====
// Package for the tempo synced fold shaper: word types, constants, sine table builder
// and small residue helpers. No dependencies.
package tsfs_pkg;

  localparam int MIN_DIVISION_Q8 = 64;
  localparam int MAX_DIVISION_Q8 = 4096;
  localparam int SINE_TABLE_BITS = 10;

  localparam int TIME_W   = 48;
  localparam int BPM_W    = 14;
  localparam int DIV_W    = 14;
  localparam int LEN_W    = 16;
  localparam int FOLD_W   = 17;
  localparam int RADIUS_W = 17;
  localparam int DIVC_W   = $clog2(MAX_DIVISION_Q8 + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIVISION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAP_DEPTH    = 2'd3;

  localparam logic [DIV_W-1:0]    RATE_DIV_RESET    = 14'd1024;
  localparam logic [LEN_W-1:0]    PHASE_OFS_RESET   = 16'd0;
  localparam logic [LEN_W-1:0]    BASE_RADIUS_RESET = 16'd256;
  localparam logic [LEN_W-1:0]    FLAP_DEPTH_RESET  = 16'd128;

  localparam logic [BPM_W-1:0]    BPM_MIN      = 14'd16;
  localparam logic [24:0]         RECIP15      = 25'd17895698;
  localparam int                  RECIP15_SHIFT = 28;
  localparam logic [13:0]         FRAC_018_Q16 = 14'd11796;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 17'd131071;
  localparam logic [FOLD_W-1:0]   WAVE_MID     = 17'd32768;
  localparam logic [17:0]         SMOOTH_3X    = 18'd196608;
  localparam logic [15:0]         QUARTER_TURN = 16'd16384;

  localparam int SINE_SHIFT   = 16 - SINE_TABLE_BITS;
  localparam int SINE_IDX_W   = SINE_TABLE_BITS - 1;
  localparam int SINE_ENTRIES = 2 ** (SINE_TABLE_BITS - 2) + 1;
  localparam logic [SINE_IDX_W-1:0] SINE_QUARTER = SINE_IDX_W'(2 ** (SINE_TABLE_BITS - 2));

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef struct packed {
    logic [TIME_W-1:0] time_seconds;
    logic [BPM_W-1:0]  tempo_bpm;
  } tsfs_in_t;

  typedef struct packed {
    logic [FOLD_W-1:0]   fold_level;
    logic [RADIUS_W-1:0] collision_radius;
  } tsfs_out_t;

  typedef struct packed {
    logic                  neg;
    logic [SINE_IDX_W-1:0] idx;
  } sine_sel_t;

  // Quarter-wave sine, Q1.16 result; evaluated at elaboration to fill the table
  function automatic logic [FOLD_W-1:0] quarter_sine(input logic [14:0] r);
    logic [63:0] th, t2, a, b, c, d, s, s16;
    th = (64'(r) * TWO_PI_Q30) >> 16;
    t2 = (th * th) >> 30;
    a = Q30_ONE - t2 / 64'd72;
    b = Q30_ONE - ((t2 * a) >> 30) / 64'd42;
    c = Q30_ONE - ((t2 * b) >> 30) / 64'd20;
    d = Q30_ONE - ((t2 * c) >> 30) / 64'd6;
    s = (th * d) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    s16 = (s + 64'd8192) >> 14;
    if (s16 > 64'd65536) begin
      s16 = 64'd65536;
    end
    return s16[FOLD_W-1:0];
  endfunction

  // Truncate a turn angle to the table grid and fold it to a quarter wave
  function automatic sine_sel_t turn_index(input logic [15:0] angle);
    sine_sel_t sel;
    logic [SINE_TABLE_BITS-3:0] q_r;
    q_r = angle[13:SINE_SHIFT];
    sel.neg = angle[15];
    sel.idx = angle[14] ? (SINE_QUARTER - {1'b0, q_r}) : {1'b0, q_r};
    return sel;
  endfunction

  function automatic logic [3:0] mod15_fold(input logic [7:0] v);
    logic [4:0] s;
    s = {1'b0, v[7:4]} + {1'b0, v[3:0]};
    if (s >= 5'd15) begin
      s = s - 5'd15;
    end
    if (s >= 5'd15) begin
      s = s - 5'd15;
    end
    return s[3:0];
  endfunction

  function automatic logic [5:0] nib_sum16(input logic [15:0] v);
    return 6'(v[15:12]) + 6'(v[11:8]) + 6'(v[7:4]) + 6'(v[3:0]);
  endfunction

  function automatic logic [3:0] mod15_48(input logic [47:0] v);
    logic [7:0] s;
    s = 8'(nib_sum16(v[47:32])) + 8'(nib_sum16(v[31:16])) + 8'(nib_sum16(v[15:0]));
    return mod15_fold(s);
  endfunction

  function automatic logic [3:0] mod15_mul(input logic [3:0] a, input logic [3:0] b);
    return mod15_fold(8'(a) * 8'(b));
  endfunction

endpackage

// ===== hw/rtl/tempo_synced_fold_shaper.sv =====
// Input words pass through 14 registered stages from input accept to output valid.
// Throughput: one word per cycle while out_ready holds; every stage has a valid bit
// and enable, so a stalled output still lets words in until the 14 stages are full.
// Reset (rst_n low, synchronous): clears all stage valid bits and loads the
// register defaults (division 1024, offset 0, radius 256, flap depth 128).
//
// Fold shaper top level: phase accumulation, sine, double smoothstep, radius.
// Depends on tsfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tempo_synced_fold_shaper
  import tsfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tsfs_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tsfs_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTAGES = 14;

  logic [DIV_W-1:0]  rate_div_r;
  logic [LEN_W-1:0]  phase_ofs_r;
  logic [LEN_W-1:0]  base_radius_r;
  logic [LEN_W-1:0]  flap_depth_r;

  logic [NSTAGES-1:0] vld_r;
  logic [NSTAGES-1:0] vld_nxt;
  logic [NSTAGES-1:0] stg_en;

  logic [DIVC_W-1:0] div_c;
  logic [BPM_W-1:0]  bpm_c;

  logic [31:0]       s1_l_r;
  logic [3:0]        s1_res_r;
  logic [31:0]       s2_l_r;
  logic [3:0]        s2_res_r;
  logic [19:0]       s3_y_r;
  logic [15:0]       s4_raw_r;
  sine_sel_t         s5_sel_r;
  logic [FOLD_W-1:0] s6_x_r;
  logic [32:0]       s7_sq_r;
  logic [17:0]       s7_coef_r;
  logic [FOLD_W-1:0] s8_y_r;
  logic [32:0]       s9_sq_r;
  logic [17:0]       s9_coef_r;
  logic [FOLD_W-1:0] s10_fold_r;
  sine_sel_t         s11_sel_r;
  logic [FOLD_W-1:0] s11_fold_r;
  logic [FOLD_W-1:0] s12_cmag_r;
  logic [14:0]       s12_floor_r;
  logic [FOLD_W-1:0] s12_fold_r;
  logic [17:0]       s13_reach_r;
  logic [FOLD_W-1:0] s13_fold_r;
  tsfs_out_t         s14_out_r;

  logic [FOLD_W-1:0] sine_lut [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
    localparam logic [FOLD_W-1:0] SINE_VAL = quarter_sine(15'(g << SINE_SHIFT));
    assign sine_lut[g] = SINE_VAL;
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_div_r    <= RATE_DIV_RESET;
      phase_ofs_r   <= PHASE_OFS_RESET;
      base_radius_r <= BASE_RADIUS_RESET;
      flap_depth_r  <= FLAP_DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE_DIVISION: rate_div_r    <= cfg_data[DIV_W-1:0];
        CFG_PHASE_OFFSET:  phase_ofs_r   <= cfg_data;
        CFG_BASE_RADIUS:   base_radius_r <= cfg_data;
        CFG_FLAP_DEPTH:    flap_depth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: advance a stage when it is empty or the next one advances
  always_comb begin
    stg_en[NSTAGES-1] = !vld_r[NSTAGES-1] || out_ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      stg_en[i] = !vld_r[i] || stg_en[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NSTAGES; i++) begin
      if (i == 0) begin
        vld_nxt[i] = stg_en[i] ? in_valid : vld_r[i];
      end else begin
        vld_nxt[i] = stg_en[i] ? vld_r[i-1] : vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[NSTAGES-1];
  assign out_data  = s14_out_r;

  always_comb begin
    if (rate_div_r < DIV_W'(MIN_DIVISION_Q8)) begin
      div_c = DIVC_W'(MIN_DIVISION_Q8);
    end else if (rate_div_r > DIV_W'(MAX_DIVISION_Q8)) begin
      div_c = DIVC_W'(MAX_DIVISION_Q8);
    end else begin
      div_c = DIVC_W'(rate_div_r);
    end
  end

  assign bpm_c = (in_data.tempo_bpm < BPM_MIN) ? BPM_MIN : in_data.tempo_bpm;

  // Phase product: low 32 bits and residue mod 15, joined afterwards
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_l_r   <= in_data.time_seconds[31:0] * 32'(bpm_c);
      s1_res_r <= mod15_mul(mod15_48(in_data.time_seconds), mod15_48(48'(bpm_c)));
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s2_l_r   <= s1_l_r * 32'(div_c);
      s2_res_r <= mod15_mul(s1_res_r, mod15_48(48'(div_c)));
    end
  end

  logic [3:0] s3_lm;
  logic [3:0] s3_k;

  always_comb begin
    s3_lm = mod15_48(48'(s2_l_r));
    if (s2_res_r >= s3_lm) begin
      s3_k = s2_res_r - s3_lm;
    end else begin
      s3_k = s2_res_r + 4'd15 - s3_lm;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s3_y_r <= {s3_k, s2_l_r[31:16]};
    end
  end

  logic [44:0] s4_prod;
  assign s4_prod = 45'(s3_y_r) * 45'(RECIP15);

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      s4_raw_r <= s4_prod[RECIP15_SHIFT +: 16];
    end
  end

  logic [15:0] s5_phase;
  assign s5_phase = s4_raw_r + phase_ofs_r;

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s5_sel_r <= turn_index(s5_phase);
    end
  end

  logic [FOLD_W-1:0] s6_half;
  assign s6_half = sine_lut[s5_sel_r.idx] >> 1;

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      s6_x_r <= s5_sel_r.neg ? (WAVE_MID - s6_half) : (WAVE_MID + s6_half);
    end
  end

  // First smoothstep
  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      s7_sq_r   <= 33'(s6_x_r) * 33'(s6_x_r);
      s7_coef_r <= SMOOTH_3X - {s6_x_r, 1'b0};
    end
  end

  logic [50:0] s8_p;
  assign s8_p = 51'(s7_sq_r) * 51'(s7_coef_r) + 51'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      s8_y_r <= s8_p[48:32];
    end
  end

  // Second smoothstep
  always_ff @(posedge clk) begin
    if (stg_en[8]) begin
      s9_sq_r   <= 33'(s8_y_r) * 33'(s8_y_r);
      s9_coef_r <= SMOOTH_3X - {s8_y_r, 1'b0};
    end
  end

  logic [50:0] s10_p;
  assign s10_p = 51'(s9_sq_r) * 51'(s9_coef_r) + 51'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (stg_en[9]) begin
      s10_fold_r <= s10_p[48:32];
    end
  end

  // Cosine angle: quarter of the fold, rounded, plus a quarter turn
  logic [17:0] s11_fp2;
  logic [15:0] s11_ang;
  assign s11_fp2 = 18'(s10_fold_r) + 18'd2;
  assign s11_ang = s11_fp2[17:2] + QUARTER_TURN;

  always_ff @(posedge clk) begin
    if (stg_en[10]) begin
      s11_sel_r  <= turn_index(s11_ang);
      s11_fold_r <= s10_fold_r;
    end
  end

  logic [30:0] s12_fl_prod;
  assign s12_fl_prod = 31'(flap_depth_r) * 31'(FRAC_018_Q16) + 31'd32768;

  always_ff @(posedge clk) begin
    if (stg_en[11]) begin
      s12_cmag_r  <= s11_sel_r.neg ? '0 : sine_lut[s11_sel_r.idx];
      s12_floor_r <= s12_fl_prod[30:16];
      s12_fold_r  <= s11_fold_r;
    end
  end

  logic [33:0] s13_prod;
  logic [17:0] s13_reach;
  assign s13_prod  = 34'(flap_depth_r) * 34'(s12_cmag_r) + 34'd32768;
  assign s13_reach = s13_prod[33:16];

  always_ff @(posedge clk) begin
    if (stg_en[12]) begin
      s13_reach_r <= (s13_reach > 18'(s12_floor_r)) ? s13_reach : 18'(s12_floor_r);
      s13_fold_r  <= s12_fold_r;
    end
  end

  logic [18:0] s14_sum;
  assign s14_sum = 19'(base_radius_r) + 19'(s13_reach_r);

  always_ff @(posedge clk) begin
    if (stg_en[13]) begin
      s14_out_r.fold_level       <= s13_fold_r;
      s14_out_r.collision_radius <= (s14_sum > 19'(RADIUS_MAX)) ? RADIUS_MAX
                                                                : s14_sum[RADIUS_W-1:0];
    end
  end

  `ASSERT_NEXT(a_word_count, clk, rst_n, 1'b1, ($countones(vld_r) == $countones($past(vld_r)) + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))), "pipeline dropped or duplicated a word")
  `ASSERT_IMPL(a_bubble_accept, clk, rst_n, !(&vld_r), in_ready, "input blocked with an empty stage")
  `ASSERT_IMPL(a_fold_range, clk, rst_n, out_valid, (out_data.fold_level <= 17'd65536), "fold level above one")
  `ASSERT_IMPL(a_radius_floor, clk, rst_n, out_valid, (out_data.collision_radius >= 17'(base_radius_r)), "radius below base radius")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for tempo_synced_fold_shaper: a directed table, then random words
// under several register settings, checked against a built-in predictor or typed results.
// Depends on tsfs_pkg and the fold shaper RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsfs_pkg::*;

  localparam logic [63:0] PHASE_MOD  = 64'd15 << 32;
  localparam logic [63:0] PHASE_DIV  = 64'd983040;
  localparam int          ANGLE_DROP = 16 - SINE_TABLE_BITS;
  localparam int          PHASES     = 7;
  localparam int          PHASE_WORDS = 250;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    tsfs_in_t              word;
    logic                  typed;
    tsfs_out_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tsfs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tsfs_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [DIV_W-1:0] rate_div_reg = RATE_DIV_RESET;
  logic [LEN_W-1:0] phase_ofs_reg = PHASE_OFS_RESET;
  logic [LEN_W-1:0] base_radius_reg = BASE_RADIUS_RESET;
  logic [LEN_W-1:0] flap_depth_reg = FLAP_DEPTH_RESET;

  tsfs_out_t pending_results[$];
  tsfs_out_t oldest;
  dir_row_t dir_rows[$];
  int err_count = 0;
  bit steady = 1'b0;

  tempo_synced_fold_shaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] sine_turns(input logic [15:0] angle, output logic neg);
    logic [15:0] q;
    logic [63:0] r, th, t2, a, b, c, d, s, s16;
    q = (angle >> ANGLE_DROP) << ANGLE_DROP;
    neg = q[15];
    r = 64'(q[13:0]);
    if (q[14]) begin
      r = 64'd16384 - r;
    end
    th = (r * TWO_PI_Q30) >> 16;
    t2 = (th * th) >> 30;
    a = Q30_ONE - t2 / 64'd72;
    b = Q30_ONE - ((t2 * a) >> 30) / 64'd42;
    c = Q30_ONE - ((t2 * b) >> 30) / 64'd20;
    d = Q30_ONE - ((t2 * c) >> 30) / 64'd6;
    s = (th * d) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    s16 = (s + 64'd8192) >> 14;
    return (s16 > 64'd65536) ? 64'd65536 : s16;
  endfunction

  function automatic logic [63:0] smooth_q16(input logic [63:0] x);
    logic [63:0] p;
    p = x * x * (64'd196608 - 64'd2 * x);
    return (p + (64'd1 << 31)) >> 32;
  endfunction

  function automatic tsfs_out_t fold_shape_predict(input tsfs_in_t w);
    tsfs_out_t res;
    logic [63:0] bpm, dv, acc, mag, wave, fold, cmag, reach, floor_len, rad;
    logic [15:0] phase;
    logic neg;
    bpm = 64'(w.tempo_bpm);
    if (bpm < 64'(BPM_MIN)) begin
      bpm = 64'(BPM_MIN);
    end
    dv = 64'(rate_div_reg);
    if (dv < 64'(MIN_DIVISION_Q8)) begin
      dv = 64'(MIN_DIVISION_Q8);
    end
    if (dv > 64'(MAX_DIVISION_Q8)) begin
      dv = 64'(MAX_DIVISION_Q8);
    end
    acc = 64'(w.time_seconds) % PHASE_MOD;
    acc = (acc * bpm) % PHASE_MOD;
    acc = (acc * dv) % PHASE_MOD;
    phase = 16'(acc / PHASE_DIV + 64'(phase_ofs_reg));
    mag = sine_turns(phase, neg);
    wave = neg ? 64'd32768 - (mag >> 1) : 64'd32768 + (mag >> 1);
    fold = smooth_q16(smooth_q16(wave));
    cmag = sine_turns(16'(((fold + 64'd2) >> 2) + 64'd16384), neg);
    if (neg) begin
      cmag = 64'd0;
    end
    reach = (64'(flap_depth_reg) * cmag + 64'd32768) >> 16;
    floor_len = (64'(flap_depth_reg) * 64'(FRAC_018_Q16) + 64'd32768) >> 16;
    rad = 64'(base_radius_reg) + ((reach > floor_len) ? reach : floor_len);
    if (rad > 64'(RADIUS_MAX)) begin
      rad = 64'(RADIUS_MAX);
    end
    res.fold_level = fold[FOLD_W-1:0];
    res.collision_radius = rad[RADIUS_W-1:0];
    return res;
  endfunction

  function automatic dir_row_t item_row(input logic [TIME_W-1:0] t, input logic [BPM_W-1:0] bpm);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.word.time_seconds = t;
    row.word.tempo_bpm = bpm;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic [TIME_W-1:0] t,
                                         input logic [BPM_W-1:0] bpm,
                                         input logic [FOLD_W-1:0] fold,
                                         input logic [RADIUS_W-1:0] rad);
    dir_row_t row;
    row = item_row(t, bpm);
    row.typed = 1'b1;
    row.want.fold_level = fold;
    row.want.collision_radius = rad;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RATE_DIVISION: rate_div_reg = val[DIV_W-1:0];
      CFG_PHASE_OFFSET:  phase_ofs_reg = val;
      CFG_BASE_RADIUS:   base_radius_reg = val;
      CFG_FLAP_DEPTH:    flap_depth_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_item(input tsfs_in_t w, input tsfs_out_t want);
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, want};
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", 32'(out_data.fold_level), 0);
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.fold_level !== oldest.fold_level) begin
          report_mismatch("fold_level", 32'(out_data.fold_level), 32'(oldest.fold_level));
        end
        if (out_data.collision_radius !== oldest.collision_radius) begin
          report_mismatch("collision_radius", 32'(out_data.collision_radius),
                          32'(oldest.collision_radius));
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 22);
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    dir_row_t row;
    tsfs_in_t w;
    logic [CFG_DATA_W-1:0] rate_pick[8];
    logic [CFG_DATA_W-1:0] rate_val, ofs_val, base_val, depth_val;

    rate_pick = '{16'd0, 16'd63, 16'd64, 16'd1024, 16'd4096, 16'd4097, 16'h3FFF, 16'hFFFF};
    dir_rows = '{
      item_row(48'd0, 14'd0),
      item_row(48'hFFFF_FFFF_FFFF, 14'h3FFF),
      item_row(48'd65536, 14'd960),
      item_row(48'd65536, 14'd15),
      item_row(48'h8000_0000_0000, 14'h2000),
      reg_row(CFG_FLAP_DEPTH, 16'd0),
      reg_row(CFG_BASE_RADIUS, 16'hFFFF),
      typed_row(48'd0, 14'd960, 17'd32768, 17'd65535),
      typed_row(48'd16384, 14'd960, 17'd65536, 17'd65535),
      typed_row(48'd49152, 14'd960, 17'd0, 17'd65535),
      reg_row(CFG_BASE_RADIUS, 16'd0),
      typed_row(48'd0, 14'd0, 17'd32768, 17'd0),
      reg_row(CFG_PHASE_OFFSET, 16'hFFFF),
      item_row(48'd0, 14'd0),
      reg_row(CFG_PHASE_OFFSET, 16'd16384),
      typed_row(48'd0, 14'd16, 17'd65536, 17'd0),
      reg_row(CFG_FLAP_DEPTH, 16'hFFFF),
      reg_row(CFG_BASE_RADIUS, 16'hFFFF),
      item_row(48'd0, 14'd16),
      typed_row(48'd32768, 14'd960, 17'd0, 17'd131070),
      reg_row(CFG_RATE_DIVISION, 16'd0),
      item_row(48'hFFFF_FFFF_FFFF, 14'h3FFF),
      item_row(48'd123456789, 14'd1234),
      reg_row(CFG_RATE_DIVISION, 16'd63),
      item_row(48'd987654321, 14'd2000),
      reg_row(CFG_RATE_DIVISION, 16'd64),
      item_row(48'd987654321, 14'd2000),
      reg_row(CFG_RATE_DIVISION, 16'd4096),
      item_row(48'h0123_4567_89AB, 14'd1920),
      reg_row(CFG_RATE_DIVISION, 16'd4097),
      item_row(48'h0123_4567_89AB, 14'd1920),
      reg_row(CFG_RATE_DIVISION, 16'h3FFF),
      item_row(48'hFFFF_FFFF_FFFF, 14'h3FFF),
      item_row(48'h5555_5555_5555, 14'h2AAA),
      reg_row(CFG_RATE_DIVISION, 16'hFFFF),
      item_row(48'hAAAA_AAAA_AAAA, 14'h1555)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.word, row.typed ? row.want : fold_shape_predict(row.word));
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        rate_val = 16'd0;
        ofs_val = 16'd0;
        base_val = 16'd0;
        depth_val = 16'd0;
      end else if (p == 1) begin
        rate_val = 16'hFFFF;
        ofs_val = 16'hFFFF;
        base_val = 16'hFFFF;
        depth_val = 16'hFFFF;
      end else begin
        rate_val = $urandom_range(1) ? rate_pick[3'($urandom_range(7))] : 16'($urandom);
        ofs_val = 16'($urandom);
        base_val = 16'($urandom_range(0, 2048));
        depth_val = 16'($urandom);
      end
      write_reg(CFG_RATE_DIVISION, rate_val);
      write_reg(CFG_PHASE_OFFSET, ofs_val);
      write_reg(CFG_BASE_RADIUS, base_val);
      write_reg(CFG_FLAP_DEPTH, depth_val);
      steady = (p == 3);

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 4 && k == PHASE_WORDS / 2) begin
          drain_results();
        end
        case ($urandom_range(3))
          0:       w.time_seconds = TIME_W'($urandom_range(0, 1 << 22));
          1:       w.time_seconds = TIME_W'($urandom_range(0, 4096)) << 16;
          default: w.time_seconds = TIME_W'({$urandom, $urandom});
        endcase
        case ($urandom_range(9))
          0:       w.tempo_bpm = BPM_W'($urandom_range(0, 15));
          1, 2:    w.tempo_bpm = BPM_W'($urandom_range(60, 200) * 16);
          default: w.tempo_bpm = BPM_W'($urandom_range(0, 16383));
        endcase
        send_item(w, fold_shape_predict(w));
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
